// ===== rtl/core/ssm_pkg.sv =====
// Package for the sparse matrix multiply block: types, codes and default sizes.
`timescale 1ns / 1ps

package ssm_pkg;

    localparam int DEF_MAX_DIM     = 64;
    localparam int DEF_MAX_NONZERO = 64;

    localparam int FUNC_W   = 2;
    localparam int IDX_W    = 6;
    localparam int VALUE_W  = 16;
    localparam int RESULT_W = 32;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 7;

    localparam logic [CFG_W-1:0] DIM_RESET = 7'd64;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD_A  = 2'd0,
        FUNC_LOAD_B  = 2'd1,
        FUNC_COMPUTE = 2'd2,
        FUNC_READ    = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK   = 2'd0,
        STATUS_FULL = 2'd1,
        STATUS_BAD  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_B_RD,
        S_B_WR,
        S_A_RD,
        S_A_BUF,
        S_A_MUL,
        S_A_WR,
        S_COL_END
    } t_state;

    typedef struct packed {
        logic [IDX_W-1:0]          row;
        logic [IDX_W-1:0]          col;
        logic signed [VALUE_W-1:0] value;
    } t_entry;

endpackage

// ===== rtl/core/ssm_stream_if.sv =====
// Valid/ready channel interfaces for the input items and the result items.
`timescale 1ns / 1ps

interface ssm_in_if;
    logic                                valid;
    logic                                ready;
    logic [ssm_pkg::FUNC_W-1:0]          func;
    logic [ssm_pkg::IDX_W-1:0]           row;
    logic [ssm_pkg::IDX_W-1:0]           col;
    logic signed [ssm_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output func, output row, output col, output value,
                    input ready);
    modport sink (input valid, input func, input row, input col, input value,
                  output ready);
endinterface

interface ssm_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [ssm_pkg::RESULT_W-1:0] read_value;
    logic [ssm_pkg::STATUS_W-1:0]        status;

    modport source (output valid, output read_value, output status, input ready);
    modport sink (input valid, input read_value, input status, output ready);
endinterface

// ===== rtl/core/ssm_entry_mem.sv =====
// Coordinate entry store: one write port, one registered read port.
`timescale 1ns / 1ps

module ssm_entry_mem #(
    parameter int DEPTH = ssm_pkg::DEF_MAX_NONZERO,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  ssm_pkg::t_entry  i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output ssm_pkg::t_entry  o_rdata
);

    ssm_pkg::t_entry r_mem [DEPTH];
    ssm_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // Read data holds until the next read.
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/ssm_col_buf.sv =====
// Dense column buffer with per-entry valid bits that a single clear resets together.
`timescale 1ns / 1ps

module ssm_col_buf #(
    parameter int MAX_DIM = ssm_pkg::DEF_MAX_DIM,
    parameter int AW      = $clog2(MAX_DIM)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_clr,
    input  logic                               i_we,
    input  logic [AW-1:0]                      i_waddr,
    input  logic signed [ssm_pkg::VALUE_W-1:0] i_wdata,
    input  logic                               i_re,
    input  logic [AW-1:0]                      i_raddr,
    output logic signed [ssm_pkg::VALUE_W-1:0] o_rdata
);

    logic signed [ssm_pkg::VALUE_W-1:0] r_mem [MAX_DIM];
    logic signed [ssm_pkg::VALUE_W-1:0] r_rdata;
    logic [MAX_DIM-1:0]                 r_valid;
    logic                               r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_clr) begin
                r_valid <= '0;
            end else if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rvalid <= r_valid[i_raddr];
            end
        end
    end

    // An entry not written since the last clear reads as zero.
    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

// ===== rtl/core/ssm_prod_mem.sv =====
// Product store with a zero sweep after reset and one read, one write port.
`timescale 1ns / 1ps

module ssm_prod_mem #(
    parameter int DEPTH = ssm_pkg::DEF_MAX_DIM * ssm_pkg::DEF_MAX_DIM,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_we,
    input  logic [AW-1:0]                       i_waddr,
    input  logic [ssm_pkg::RESULT_W-1:0]        i_wdata,
    input  logic                                i_re,
    input  logic [AW-1:0]                       i_raddr,
    output logic [ssm_pkg::RESULT_W-1:0]        o_rdata,
    output logic                                o_busy
);

    logic [ssm_pkg::RESULT_W-1:0] r_mem [DEPTH];
    logic [ssm_pkg::RESULT_W-1:0] r_rdata;
    logic [AW:0]                  r_sweep;
    logic                         w_busy;
    logic                         w_we;
    logic [AW-1:0]                w_waddr;
    logic [ssm_pkg::RESULT_W-1:0] w_wdata;

    assign w_busy  = (32'(r_sweep) < DEPTH);
    assign w_we    = w_busy | i_we;
    assign w_waddr = w_busy ? r_sweep[AW-1:0] : i_waddr;
    assign w_wdata = w_busy ? '0 : i_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
        end else if (w_busy) begin
            r_sweep <= r_sweep + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = w_busy;

endmodule

// ===== rtl/core/sparse_sparse_matmul_coo_top.sv =====
// Top level of the sparse times sparse matrix multiply on coordinate entries.
//
//  Channel   Dir  Handshake     Carries
//  i_in      in   valid/ready   func, row, col, value
//  o_out     out  valid/ready   read_value, status
//  i_cfg_*   in   write enable  dimension
//
// A load item is answered from the idle state; a read item also passes S_RD for the
// product store read. A compute item runs over each column of dimension d and the nA, nB
// stored entries; each A entry is a read, modify, write on the product store.
// After reset the product store is swept to zero, all MAX_DIM*MAX_DIM entries, during
// which no item is accepted. A result waits in an output register; the next item
// is taken in the cycle that result is taken.
`timescale 1ns / 1ps

module sparse_sparse_matmul_coo_top #(
    parameter int MAX_DIM     = ssm_pkg::DEF_MAX_DIM,
    parameter int MAX_NONZERO = ssm_pkg::DEF_MAX_NONZERO
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [ssm_pkg::CFG_W-1:0]   i_cfg_wdata,
    ssm_in_if.sink                      i_in,
    ssm_out_if.source                   o_out
);

    localparam int EAW = (MAX_NONZERO > 1) ? $clog2(MAX_NONZERO) : 1;
    localparam int CW  = $clog2(MAX_NONZERO + 1);
    localparam int BAW = $clog2(MAX_DIM);
    localparam int DW  = $clog2(MAX_DIM + 1);
    localparam int PD  = MAX_DIM * MAX_DIM;
    localparam int PAW = $clog2(PD);

    ssm_pkg::t_state r_state, n_state;
    logic [ssm_pkg::CFG_W-1:0] r_dim;
    logic [CW-1:0]  r_cnt_a, n_cnt_a, r_cnt_b, n_cnt_b;
    logic [CW-1:0]  r_k, n_k;
    logic [DW-1:0]  r_col, n_col;
    logic [PAW-1:0] r_paddr, n_paddr;
    logic signed [ssm_pkg::RESULT_W-1:0] r_mul, n_mul;
    logic           r_out_valid, n_out_valid;
    logic [ssm_pkg::RESULT_W-1:0] r_out_value, n_out_value;
    ssm_pkg::t_status r_out_status, n_out_status;

    logic [DW-1:0]  w_dim;
    logic           w_accept;
    logic           w_out_free;
    logic           w_bad;
    ssm_pkg::t_entry w_in_entry;

    logic            a_we, a_re, b_we, b_re;
    logic [EAW-1:0]  a_waddr, b_waddr, e_raddr;
    ssm_pkg::t_entry a_rdata, b_rdata;
    logic            cb_clr, cb_we, cb_re;
    logic signed [ssm_pkg::VALUE_W-1:0] cb_rdata;
    logic            p_we, p_re, p_busy;
    logic [PAW-1:0]  p_raddr;
    logic [ssm_pkg::RESULT_W-1:0] p_wdata, p_rdata;

    // Dimension zero acts as 1; values above MAX_DIM act as MAX_DIM.
    always_comb begin
        if (r_dim == '0) begin
            w_dim = DW'(1);
        end else if (32'(r_dim) > MAX_DIM) begin
            w_dim = DW'(MAX_DIM);
        end else begin
            w_dim = DW'(r_dim);
        end
    end

    assign w_in_entry.row   = i_in.row;
    assign w_in_entry.col   = i_in.col;
    assign w_in_entry.value = i_in.value;
    assign w_bad      = (32'(i_in.row) >= 32'(w_dim)) || (32'(i_in.col) >= 32'(w_dim));
    assign w_out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == ssm_pkg::S_IDLE) && w_out_free;
    assign w_accept   = i_in.valid && i_in.ready;

    assign a_waddr = EAW'(r_cnt_a);
    assign b_waddr = EAW'(r_cnt_b);
    assign e_raddr = EAW'(r_k);

    always_comb begin
        n_state      = r_state;
        n_cnt_a      = r_cnt_a;
        n_cnt_b      = r_cnt_b;
        n_k          = r_k;
        n_col        = r_col;
        n_paddr      = r_paddr;
        n_mul        = r_mul;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        a_we    = 1'b0;
        b_we    = 1'b0;
        a_re    = 1'b0;
        b_re    = 1'b0;
        cb_clr  = 1'b0;
        cb_we   = 1'b0;
        cb_re   = 1'b0;
        p_we    = 1'b0;
        p_re    = 1'b0;
        p_raddr = PAW'(32'(i_in.row) * MAX_DIM + 32'(i_in.col));
        p_wdata = p_rdata + r_mul;

        case (r_state)
            ssm_pkg::S_CLEAR: begin
                if (!p_busy) begin
                    n_state = ssm_pkg::S_IDLE;
                end
            end
            ssm_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_out_value = '0;
                    case (ssm_pkg::t_func'(i_in.func))
                        ssm_pkg::FUNC_LOAD_A, ssm_pkg::FUNC_LOAD_B: begin
                            n_out_valid = 1'b1;
                            if (w_bad) begin
                                n_out_status = ssm_pkg::STATUS_BAD;
                            end else if (i_in.func == ssm_pkg::FUNC_LOAD_A) begin
                                if (32'(r_cnt_a) >= MAX_NONZERO) begin
                                    n_out_status = ssm_pkg::STATUS_FULL;
                                end else begin
                                    n_out_status = ssm_pkg::STATUS_OK;
                                    a_we    = 1'b1;
                                    n_cnt_a = r_cnt_a + 1'b1;
                                end
                            end else begin
                                if (32'(r_cnt_b) >= MAX_NONZERO) begin
                                    n_out_status = ssm_pkg::STATUS_FULL;
                                end else begin
                                    n_out_status = ssm_pkg::STATUS_OK;
                                    b_we    = 1'b1;
                                    n_cnt_b = r_cnt_b + 1'b1;
                                end
                            end
                        end
                        ssm_pkg::FUNC_COMPUTE: begin
                            n_col   = '0;
                            n_k     = '0;
                            n_state = ssm_pkg::S_B_RD;
                        end
                        ssm_pkg::FUNC_READ: begin
                            if (w_bad) begin
                                n_out_valid  = 1'b1;
                                n_out_status = ssm_pkg::STATUS_BAD;
                            end else begin
                                p_re    = 1'b1;
                                n_state = ssm_pkg::S_RD;
                            end
                        end
                        default: begin
                            n_state = ssm_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            ssm_pkg::S_RD: begin
                n_out_valid  = 1'b1;
                n_out_value  = p_rdata;
                n_out_status = ssm_pkg::STATUS_OK;
                n_state      = ssm_pkg::S_IDLE;
            end
            ssm_pkg::S_B_RD: begin
                if (r_k == r_cnt_b) begin
                    n_k     = '0;
                    n_state = ssm_pkg::S_A_RD;
                end else begin
                    b_re    = 1'b1;
                    n_state = ssm_pkg::S_B_WR;
                end
            end
            ssm_pkg::S_B_WR: begin
                // Entries are taken in load order, so a later one overwrites.
                cb_we   = (32'(b_rdata.col) == 32'(r_col));
                n_k     = r_k + 1'b1;
                n_state = ssm_pkg::S_B_RD;
            end
            ssm_pkg::S_A_RD: begin
                if (r_k == r_cnt_a) begin
                    n_state = ssm_pkg::S_COL_END;
                end else begin
                    a_re    = 1'b1;
                    n_state = ssm_pkg::S_A_BUF;
                end
            end
            ssm_pkg::S_A_BUF: begin
                cb_re   = 1'b1;
                p_re    = 1'b1;
                p_raddr = PAW'(32'(a_rdata.row) * MAX_DIM + 32'(r_col));
                n_paddr = p_raddr;
                n_state = ssm_pkg::S_A_MUL;
            end
            ssm_pkg::S_A_MUL: begin
                n_mul   = ssm_pkg::RESULT_W'(a_rdata.value) * ssm_pkg::RESULT_W'(cb_rdata);
                n_state = ssm_pkg::S_A_WR;
            end
            ssm_pkg::S_A_WR: begin
                p_we    = 1'b1;
                n_k     = r_k + 1'b1;
                n_state = ssm_pkg::S_A_RD;
            end
            ssm_pkg::S_COL_END: begin
                cb_clr = 1'b1;
                n_k    = '0;
                if (r_col + 1'b1 == w_dim) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = '0;
                    n_out_status = ssm_pkg::STATUS_OK;
                    n_state      = ssm_pkg::S_IDLE;
                end else begin
                    n_col   = r_col + 1'b1;
                    n_state = ssm_pkg::S_B_RD;
                end
            end
            default: begin
                n_state = ssm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ssm_pkg::S_CLEAR;
            r_dim       <= ssm_pkg::DIM_RESET;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_k         <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt_a     <= n_cnt_a;
            r_cnt_b     <= n_cnt_b;
            r_k         <= n_k;
            r_col       <= n_col;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_dim <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_paddr      <= n_paddr;
        r_mul        <= n_mul;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.read_value = r_out_value;
    assign o_out.status     = r_out_status;

    ssm_entry_mem #(.DEPTH(MAX_NONZERO), .AW(EAW)) u_a_mem (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (w_in_entry),
        .i_re    (a_re),
        .i_raddr (e_raddr),
        .o_rdata (a_rdata)
    );

    ssm_entry_mem #(.DEPTH(MAX_NONZERO), .AW(EAW)) u_b_mem (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (w_in_entry),
        .i_re    (b_re),
        .i_raddr (e_raddr),
        .o_rdata (b_rdata)
    );

    ssm_col_buf #(.MAX_DIM(MAX_DIM), .AW(BAW)) u_col_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (cb_clr),
        .i_we    (cb_we),
        .i_waddr (BAW'(b_rdata.row)),
        .i_wdata (b_rdata.value),
        .i_re    (cb_re),
        .i_raddr (BAW'(a_rdata.col)),
        .o_rdata (cb_rdata)
    );

    ssm_prod_mem #(.DEPTH(PD), .AW(PAW)) u_prod_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (p_we),
        .i_waddr (r_paddr),
        .i_wdata (p_wdata),
        .i_re    (p_re),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata),
        .o_busy  (p_busy)
    );

endmodule
